// ===== rtl/dqc_pkg.sv =====
// Shared types and constants for the dotted-quad checker.
// No dependencies; every other file refers to it by scoped names.

package dqc_pkg;

    // Field widths
    localparam int unsigned SymbolWidth  = 8;
    localparam int unsigned VerdictWidth = 2;
    localparam int unsigned OctetWidth   = 9;
    localparam int unsigned DotWidth     = 3;

    // Character codes
    localparam logic [SymbolWidth-1:0] CharZero = 8'h30;
    localparam logic [SymbolWidth-1:0] CharNine = 8'h39;
    localparam logic [SymbolWidth-1:0] CharDot  = 8'h2E;

    // Octet limits: the accumulator saturates one above the largest octet
    localparam logic [OctetWidth-1:0] OctetMax = 9'd255;
    localparam logic [OctetWidth-1:0] OctetSat = 9'd256;

    // Dot counting: count saturates one above the required number
    localparam logic [DotWidth-1:0] DotsNeeded = 3'd3;
    localparam logic [DotWidth-1:0] DotsSat    = 3'd4;

    // First fault seen while scanning
    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_RANGE    = 2'd1,
        FAULT_NONDIGIT = 2'd2
    } fault_t;

    // Verdict codes
    localparam logic [VerdictWidth-1:0] VerdictRange  = 2'd0;
    localparam logic [VerdictWidth-1:0] VerdictValid  = 2'd1;
    localparam logic [VerdictWidth-1:0] VerdictDomain = 2'd2;

    // One character moving from the input register into the scanner
    typedef struct packed {
        logic                   valid;
        logic [SymbolWidth-1:0] symbol;
        logic                   final_char;
    } step_t;

    // Verdict moving from the scanner into the result register
    typedef struct packed {
        logic                    load;
        logic [VerdictWidth-1:0] verdict;
    } result_t;

endpackage

// ===== rtl/dqc_if.sv =====
// Handshake channels for the dotted-quad checker: character beats in, verdict beats out.
// Depends on dqc_pkg for field widths.

interface dqc_char_if;
    logic                           valid;
    logic                           ready;
    logic [dqc_pkg::SymbolWidth-1:0] symbol;
    logic                           final_char;

    modport source (output valid, output symbol, output final_char, input ready);
    modport sink   (input valid, input symbol, input final_char, output ready);
endinterface

interface dqc_verdict_if;
    logic                            valid;
    logic                            ready;
    logic [dqc_pkg::VerdictWidth-1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// ===== rtl/dqc_in_reg.sv =====
// Input register of the dotted-quad checker: holds one character beat.
// Depends on dqc_pkg and dqc_char_if.

module dqc_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    dqc_char_if.sink           chars,
    input  logic               out_free,
    output dqc_pkg::step_t     step
);

    logic                            valid_reg;
    logic [dqc_pkg::SymbolWidth-1:0] symbol_reg;
    logic                            final_reg;
    logic                            advance;

    // Advance a non-final beat always; a final beat only when the result register frees
    assign advance     = valid_reg && (!final_reg || out_free);
    assign chars.ready = !valid_reg || advance;

    assign step.valid      = advance;
    assign step.symbol     = symbol_reg;
    assign step.final_char = final_reg;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            valid_reg <= chars.valid;
        end
    end

    // Capture the payload on each accepted beat
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            symbol_reg <= chars.symbol;
            final_reg  <= chars.final_char;
        end
    end

endmodule

// ===== rtl/dqc_scan.sv =====
// Scan state of the dotted-quad checker: octet accumulator, dot count and fault flags.
// Depends on dqc_pkg.

module dqc_scan
(
    input  logic               clk,
    input  logic               rst_n,
    input  dqc_pkg::step_t     step,
    output dqc_pkg::result_t   result
);

    logic [dqc_pkg::OctetWidth-1:0] octet_reg, octet_next;
    logic [dqc_pkg::DotWidth-1:0]   dots_reg, dots_next;
    logic                           prev_dot_reg, prev_dot_next;
    logic                           at_start_reg, at_start_next;
    logic                           bad_reg, bad_next;
    dqc_pkg::fault_t                fault_reg, fault_next;

    logic        is_dot;
    logic        is_digit;
    logic [3:0]  digit;
    logic [12:0] product;
    logic        final_bad;
    dqc_pkg::fault_t final_fault;

    assign is_dot   = (step.symbol == dqc_pkg::CharDot);
    assign is_digit = (step.symbol >= dqc_pkg::CharZero) && (step.symbol <= dqc_pkg::CharNine);
    assign digit    = 4'(step.symbol - dqc_pkg::CharZero);

    // Multiply by ten as two shifts and an add, then add the digit
    assign product = {1'b0, octet_reg, 3'b000} + {3'b000, octet_reg, 1'b0}
                   + {9'd0, digit};

    // Update the scan state for one character
    always_comb
    begin
        octet_next    = octet_reg;
        dots_next     = dots_reg;
        prev_dot_next = prev_dot_reg;
        bad_next      = bad_reg;
        fault_next    = fault_reg;
        at_start_next = 1'b0;

        if (is_dot)
        begin
            if (at_start_reg || prev_dot_reg)
            begin
                bad_next = 1'b1;
            end
            if (dots_reg < dqc_pkg::DotsSat)
            begin
                dots_next = dots_reg + 3'd1;
            end
            if (fault_reg == dqc_pkg::FAULT_NONE && octet_reg > dqc_pkg::OctetMax)
            begin
                fault_next = dqc_pkg::FAULT_RANGE;
            end
            octet_next    = '0;
            prev_dot_next = 1'b1;
        end
        else
        begin
            prev_dot_next = 1'b0;
            if (is_digit)
            begin
                if (octet_reg < dqc_pkg::OctetSat)
                begin
                    octet_next = (product > 13'(dqc_pkg::OctetSat)) ? dqc_pkg::OctetSat
                                                                     : product[8:0];
                end
            end
            else if (fault_reg == dqc_pkg::FAULT_NONE)
            begin
                fault_next = dqc_pkg::FAULT_NONDIGIT;
            end
        end
    end

    // Close the string on its final character
    always_comb
    begin
        final_bad   = bad_next || is_dot || (dots_next != dqc_pkg::DotsNeeded);
        final_fault = fault_next;
        if (is_digit && final_fault == dqc_pkg::FAULT_NONE && octet_next > dqc_pkg::OctetMax)
        begin
            final_fault = dqc_pkg::FAULT_RANGE;
        end

        result.load = step.valid && step.final_char;
        if (final_bad)
        begin
            result.verdict = dqc_pkg::VerdictDomain;
        end
        else
        begin
            case (final_fault)
                dqc_pkg::FAULT_NONE:  result.verdict = dqc_pkg::VerdictValid;
                dqc_pkg::FAULT_RANGE: result.verdict = dqc_pkg::VerdictRange;
                default:              result.verdict = dqc_pkg::VerdictDomain;
            endcase
        end
    end

    // Advance the state per character; drop back to reset after a final one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octet_reg    <= '0;
            dots_reg     <= '0;
            prev_dot_reg <= 1'b0;
            at_start_reg <= 1'b1;
            bad_reg      <= 1'b0;
            fault_reg    <= dqc_pkg::FAULT_NONE;
        end
        else if (step.valid)
        begin
            if (step.final_char)
            begin
                octet_reg    <= '0;
                dots_reg     <= '0;
                prev_dot_reg <= 1'b0;
                at_start_reg <= 1'b1;
                bad_reg      <= 1'b0;
                fault_reg    <= dqc_pkg::FAULT_NONE;
            end
            else
            begin
                octet_reg    <= octet_next;
                dots_reg     <= dots_next;
                prev_dot_reg <= prev_dot_next;
                at_start_reg <= at_start_next;
                bad_reg      <= bad_next;
                fault_reg    <= fault_next;
            end
        end
    end

endmodule

// ===== rtl/dqc_out_reg.sv =====
// Result register of the dotted-quad checker: holds one verdict beat until taken.
// Depends on dqc_pkg and dqc_verdict_if.

module dqc_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  dqc_pkg::result_t   result,
    output logic               out_free,
    dqc_verdict_if.source      results
);

    logic                             valid_reg;
    logic [dqc_pkg::VerdictWidth-1:0] verdict_reg;

    assign out_free        = !valid_reg || results.ready;
    assign results.valid   = valid_reg;
    assign results.verdict = verdict_reg;

    // Hold the verdict until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= result.load;
        end
    end

    // Load the verdict payload
    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            verdict_reg <= result.verdict;
        end
    end

endmodule

// ===== rtl/ipv4_dotted_quad_checker.sv =====
// Top level of the dotted-quad checker: input register, scanner, result register.
// Depends on dqc_pkg, dqc_if, dqc_in_reg, dqc_scan and dqc_out_reg.
//
//   Channel   Role   Payload                      Beat
//   chars     sink   symbol[7:0], final_char      one character of the host string
//   results   source verdict[1:0]                 one verdict per string
//
// Takes one character per cycle, set by the single input register. A verdict is
// offered once the final character has moved on from the input register.
// Reset clears the scan state to the start of a string.
// The only stall comes from the result register: a final character waits in the
// input register while an earlier verdict is still untaken.

module ipv4_dotted_quad_checker
(
    input  logic          clk,
    input  logic          rst_n,
    dqc_char_if.sink      chars,
    dqc_verdict_if.source results
);

    dqc_pkg::step_t   step;
    dqc_pkg::result_t result;
    logic             out_free;

    dqc_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .out_free (out_free),
        .step     (step)
    );

    dqc_scan u_scan
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    dqc_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .out_free (out_free),
        .results  (results)
    );

endmodule

// ===== test/ipv4_dotted_quad_checker_tb.sv =====
// Self-checking testbench for the dotted-quad checker: host strings in, verdicts out.
// Depends on dqc_pkg, dqc_if and the ipv4_dotted_quad_checker RTL.
// A tracker class mirrors the scan state and queues the verdict owed for each string.

`timescale 1ns / 100ps

class quad_verdict_tracker;
    logic [dqc_pkg::OctetWidth-1:0]   octet_value;
    logic [dqc_pkg::DotWidth-1:0]     dot_count;
    logic                             previous_was_dot;
    logic                             at_start;
    logic                             structure_bad;
    dqc_pkg::fault_t                  first_fault;
    logic [dqc_pkg::VerdictWidth-1:0] pending_verdicts[$];
    int unsigned                      errors;

    function new();
        errors = 0;
        clear_scan();
    endfunction

    // Return to the start of a string
    function void clear_scan();
        octet_value      = '0;
        dot_count        = '0;
        previous_was_dot = 1'b0;
        at_start         = 1'b1;
        structure_bad    = 1'b0;
        first_fault      = dqc_pkg::FAULT_NONE;
    endfunction

    function void note_range();
        if (first_fault == dqc_pkg::FAULT_NONE && octet_value > dqc_pkg::OctetMax)
            first_fault = dqc_pkg::FAULT_RANGE;
    endfunction

    function int unsigned pending();
        return pending_verdicts.size();
    endfunction

    // Advance the scan by one accepted character beat
    function void note_char(logic [dqc_pkg::SymbolWidth-1:0] symbol, logic final_char);
        logic                             is_dot;
        logic                             is_digit;
        logic [12:0]                      grown;
        logic [dqc_pkg::VerdictWidth-1:0] verdict;
        is_dot   = (symbol == dqc_pkg::CharDot);
        is_digit = (symbol >= dqc_pkg::CharZero) && (symbol <= dqc_pkg::CharNine);
        if (is_dot)
        begin
            if (at_start || previous_was_dot)
                structure_bad = 1'b1;
            if (dot_count < dqc_pkg::DotsSat)
                dot_count = dot_count + 1'b1;
            note_range();
            octet_value      = '0;
            previous_was_dot = 1'b1;
        end
        else
        begin
            previous_was_dot = 1'b0;
            if (is_digit)
            begin
                // Saturate the octet one above the largest legal value
                if (octet_value < dqc_pkg::OctetSat)
                begin
                    grown = octet_value * 13'd10 + (symbol - dqc_pkg::CharZero);
                    octet_value = (grown > dqc_pkg::OctetSat) ? dqc_pkg::OctetSat
                                                              : grown[dqc_pkg::OctetWidth-1:0];
                end
            end
            else if (first_fault == dqc_pkg::FAULT_NONE)
            begin
                first_fault = dqc_pkg::FAULT_NONDIGIT;
            end
        end
        at_start = 1'b0;
        if (!final_char)
            return;

        // Close the string and settle the verdict
        if (is_dot)
            structure_bad = 1'b1;
        if (is_digit)
            note_range();
        if (dot_count != dqc_pkg::DotsNeeded)
            structure_bad = 1'b1;
        if (structure_bad)
            verdict = dqc_pkg::VerdictDomain;
        else if (first_fault == dqc_pkg::FAULT_NONE)
            verdict = dqc_pkg::VerdictValid;
        else if (first_fault == dqc_pkg::FAULT_RANGE)
            verdict = dqc_pkg::VerdictRange;
        else
            verdict = dqc_pkg::VerdictDomain;
        pending_verdicts.push_back(verdict);
        clear_scan();
    endfunction

    // Compare one accepted verdict beat with the oldest one owed
    function void check_verdict(logic [dqc_pkg::VerdictWidth-1:0] actual);
        logic [dqc_pkg::VerdictWidth-1:0] wanted;
        if (pending_verdicts.size() == 0)
        begin
            $error("verdict: unexpected beat, expected none, actual %0d", actual);
            errors++;
            return;
        end
        wanted = pending_verdicts.pop_front();
        if (actual !== wanted)
        begin
            $error("verdict mismatch: expected %0d, actual %0d", wanted, actual);
            errors++;
        end
    endfunction
endclass

module ipv4_dotted_quad_checker_tb;

    localparam int unsigned RandomChars   = 1750;
    localparam int unsigned WatchdogLimit = 1000;
    localparam int unsigned DrainCycles   = 8;
    localparam int unsigned IdlePercent   = 9;

    logic clk;
    logic rst_n;
    logic idle_on;
    int unsigned quiet_cycles;
    int unsigned chars_sent;
    logic [dqc_pkg::SymbolWidth-1:0] host_chars[$];
    quad_verdict_tracker tracker;

    dqc_char_if    char_ch();
    dqc_verdict_if verdict_ch();

    ipv4_dotted_quad_checker uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (char_ch.sink),
        .results (verdict_ch.source)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Stall the verdict channel at random
    always @(posedge clk)
    begin
        verdict_ch.ready <= !(idle_on && ($urandom_range(0, 99) < IdlePercent));
    end

    // Watch both channels: feed the tracker and guard against a hang
    always @(posedge clk)
    begin
        if (char_ch.valid && char_ch.ready)
            tracker.note_char(char_ch.symbol, char_ch.final_char);
        if (verdict_ch.valid && verdict_ch.ready)
            tracker.check_verdict(verdict_ch.verdict);
        if (!rst_n || (char_ch.valid && char_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("ipv4_dotted_quad_checker_tb: FAIL");
            $finish;
        end
    end

    // Offer one character beat and hold it until taken
    task automatic send_char(logic [dqc_pkg::SymbolWidth-1:0] symbol, logic final_char);
        while (idle_on && ($urandom_range(0, 99) < IdlePercent))
        begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid      <= 1'b1;
        char_ch.symbol     <= symbol;
        char_ch.final_char <= final_char;
        do
            @(posedge clk);
        while (!char_ch.ready);
        chars_sent++;
    endtask

    // Send the whole host string, flagging its last character
    task automatic send_host();
        int unsigned i;
        for (i = 0; i < host_chars.size(); i++)
            send_char(host_chars[i], i == host_chars.size() - 1);
    endtask

    task automatic load_text(string text);
        int unsigned i;
        host_chars.delete();
        for (i = 0; i < text.len(); i++)
            host_chars.push_back(text[i]);
    endtask

    // Hold off the sender until every owed verdict has arrived
    task automatic drain_verdicts();
        char_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Build a random host string: mostly dotted quads, some damaged, some noise
    task automatic build_random_host();
        int unsigned kind;
        int unsigned octets;
        int unsigned i;
        int unsigned j;
        int unsigned value;
        int unsigned pos;
        string digits;
        host_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 75)
        begin
            octets = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
            for (i = 0; i < octets; i++)
            begin
                if (i != 0)
                    host_chars.push_back(dqc_pkg::CharDot);
                case ($urandom_range(0, 9))
                    0:       value = $urandom_range(256, 999);
                    1:       value = $urandom_range(0, 9);
                    default: value = $urandom_range(0, 255);
                endcase
                if ($urandom_range(0, 7) == 0)
                    host_chars.push_back(dqc_pkg::CharZero);
                digits = $sformatf("%0d", value);
                for (j = 0; j < digits.len(); j++)
                    host_chars.push_back(digits[j]);
            end
            // Stretch the last octet into a long digit run now and then
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(4, 12))
                    host_chars.push_back(dqc_pkg::CharZero + 8'($urandom_range(0, 9)));
            // Damage a share of the quads
            if (kind >= 50)
            begin
                pos = $urandom_range(0, host_chars.size() - 1);
                case ($urandom_range(0, 3))
                    0: host_chars[pos] = 8'($urandom_range(0, 255));
                    1: host_chars.insert(pos, dqc_pkg::CharDot);
                    2: host_chars.delete(pos);
                    default: host_chars[pos] = dqc_pkg::CharDot;
                endcase
            end
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(0, 3))
                    0:       host_chars.push_back(dqc_pkg::CharDot);
                    1:       host_chars.push_back(dqc_pkg::CharZero + 8'($urandom_range(0, 9)));
                    default: host_chars.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        if (host_chars.size() == 0)
            host_chars.push_back(dqc_pkg::CharDot);
    endtask

    initial
    begin
        int unsigned strings;
        tracker              = new();
        idle_on              = 1'b1;
        chars_sent           = 0;
        rst_n                = 1'b0;
        char_ch.valid        = 1'b0;
        char_ch.symbol       = '0;
        char_ch.final_char   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: lone characters, extremes, adjacent dots, long run
        load_text(".");
        send_host();
        load_text("9");
        send_host();
        host_chars = '{8'h00};
        send_host();
        host_chars = '{8'hFF};
        send_host();
        load_text("255.0.9.1");
        send_host();
        load_text("1..2.3");
        send_host();
        load_text("99999.0.0.1");
        send_host();
        drain_verdicts();

        // Random strings, with a quiet stretch and periodic drains
        strings    = 0;
        chars_sent = 0;
        while (chars_sent < RandomChars)
        begin
            idle_on = !(strings >= 40 && strings < 70);
            build_random_host();
            send_host();
            strings++;
            if (strings % 50 == 0)
                drain_verdicts();
        end

        // Wait out the last verdicts and the pipeline
        idle_on = 1'b1;
        drain_verdicts();
        repeat (DrainCycles) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("ipv4_dotted_quad_checker_tb: PASS");
        else
            $display("ipv4_dotted_quad_checker_tb: FAIL");
        $finish;
    end

endmodule
